// ----- hw/rtl/i2cm_pkg.sv -----
// ----------------------------------------------------------------------------
// i2cm_pkg
// shared widths, command kinds and register indexes of the i2c bit engine
// ----------------------------------------------------------------------------
package i2cm_pkg;

    localparam int KIND_W  = 3;
    localparam int BYTE_W  = 8;
    localparam int TPM_W   = 10;
    localparam int TO_W    = 8;
    localparam int DELAY_W = 13;
    localparam int BITS_W  = 4;
    localparam int CFG_W   = 10;
    localparam int CFG_IDX_W = 1;

    typedef logic [KIND_W-1:0]    kind_t;
    typedef logic [BYTE_W-1:0]    byte_t;
    typedef logic [TPM_W-1:0]     tpm_t;
    typedef logic [TO_W-1:0]      timeout_t;
    typedef logic [DELAY_W-1:0]   delay_t;
    typedef logic [BITS_W-1:0]    bits_t;
    typedef logic [CFG_W-1:0]     cfg_data_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam kind_t KIND_TICK  = 3'd0;
    localparam kind_t KIND_START = 3'd1;
    localparam kind_t KIND_STOP  = 3'd2;
    localparam kind_t KIND_WRITE = 3'd3;
    localparam kind_t KIND_WACK  = 3'd4;
    localparam kind_t KIND_READ  = 3'd5;

    localparam cfg_idx_t CFG_TPM     = 1'b0;
    localparam cfg_idx_t CFG_TIMEOUT = 1'b1;

    localparam tpm_t     TPM_RESET     = 10'd1;
    localparam timeout_t TIMEOUT_RESET = 8'd250;
    localparam bits_t    BITS_PER_BYTE = 4'd8;

endpackage

// ----- hw/rtl/i2cm_if.sv -----
// ----------------------------------------------------------------------------
// i2cm_cmd_if / i2cm_res_if
// valid/ready channels for command items and result items
// ----------------------------------------------------------------------------
interface i2cm_cmd_if;
    logic              valid;
    logic              ready;
    i2cm_pkg::kind_t   kind;
    i2cm_pkg::byte_t   data_byte;
    logic              send_ack;
    logic              sda_in;

    modport source (output valid, kind, data_byte, send_ack, sda_in, input ready);
    modport sink   (input valid, kind, data_byte, send_ack, sda_in, output ready);
endinterface

interface i2cm_res_if;
    logic              valid;
    logic              ready;
    logic              scl_level;
    logic              sda_level;
    logic              sda_drive;
    logic              busy_res;
    logic              done_res;
    i2cm_pkg::byte_t   read_data;
    logic              ack_failed;

    modport source (output valid, scl_level, sda_level, sda_drive, busy_res, done_res,
                    read_data, ack_failed, input ready);
    modport sink   (input valid, scl_level, sda_level, sda_drive, busy_res, done_res,
                    read_data, ack_failed, output ready);
endinterface

// ----- hw/rtl/i2c_master_bit_engine_top.sv -----
// ----------------------------------------------------------------------------
// i2c_master_bit_engine_top
// i2c master bit sequencer: start, stop, byte write, ack wait and byte read,
// timed by tick items that also carry the sampled sda level
//
//   channel | dir | contents
//   cmd     | in  | kind, data_byte, send_ack, sda_in
//   res     | out | scl_level, sda_level, sda_drive, busy_res, done_res,
//           |     | read_data, ack_failed
//   cfg     | in  | cfg_we, cfg_index, cfg_data (write only)
//
// one item per clock while cmd.ready is high; each item yields one result in the next cycle
// the sequencer state registers are updated on the accepting edge
// the result register frees in the cycle it is taken, so cmd.ready is
// low only while a result is held and res.ready is low
// reset puts both lines high with sda driven and the sequencer idle
// ----------------------------------------------------------------------------
module i2c_master_bit_engine_top
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  i2cm_pkg::cfg_idx_t       cfg_index,
    input  i2cm_pkg::cfg_data_t      cfg_data,
    i2cm_cmd_if.sink                 cmd,
    i2cm_res_if.source               res
);

    localparam logic [3:0] PH_IDLE    = 4'd0;
    localparam logic [3:0] PH_START   = 4'd1;
    localparam logic [3:0] PH_STOP_A  = 4'd2;
    localparam logic [3:0] PH_STOP_B  = 4'd3;
    localparam logic [3:0] PH_WA_A    = 4'd4;
    localparam logic [3:0] PH_WA_B    = 4'd5;
    localparam logic [3:0] PH_WA_POLL = 4'd6;
    localparam logic [3:0] PH_SB_A    = 4'd7;
    localparam logic [3:0] PH_SB_B    = 4'd8;
    localparam logic [3:0] PH_SB_C    = 4'd9;
    localparam logic [3:0] PH_RB_A    = 4'd10;
    localparam logic [3:0] PH_RB_B    = 4'd11;
    localparam logic [3:0] PH_AK_A    = 4'd12;
    localparam logic [3:0] PH_AK_B    = 4'd13;

    i2cm_pkg::tpm_t     tpm_reg;
    i2cm_pkg::timeout_t timeout_reg;

    logic [3:0]         phase_reg,  phase_next;
    i2cm_pkg::bits_t    bits_reg,   bits_next;
    i2cm_pkg::byte_t    shift_reg,  shift_next;
    i2cm_pkg::delay_t   delay_reg,  delay_next;
    i2cm_pkg::timeout_t poll_reg,   poll_next;
    logic               ackc_reg,   ackc_next;
    logic               scl_reg,    scl_next;
    logic               sda_reg,    sda_next;
    logic               drive_reg,  drive_next;
    i2cm_pkg::byte_t    rd_reg,     rd_next;
    logic               fail_reg,   fail_next;
    logic               done_reg,   done_next;
    logic               out_valid_reg;

    logic               in_fire;
    i2cm_pkg::delay_t   dly1, dly2, dly4;
    i2cm_pkg::bits_t    bits_inc;

    assign cmd.ready = !out_valid_reg || res.ready;
    assign in_fire   = cmd.valid && cmd.ready;

    assign dly1     = {3'b000, tpm_reg};
    assign dly2     = {2'b00, tpm_reg, 1'b0};
    assign dly4     = {1'b0, tpm_reg, 2'b00};
    assign bits_inc = bits_reg + 4'd1;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tpm_reg     <= i2cm_pkg::TPM_RESET;
            timeout_reg <= i2cm_pkg::TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                i2cm_pkg::CFG_TPM:     tpm_reg     <= cfg_data;
                i2cm_pkg::CFG_TIMEOUT: timeout_reg <= cfg_data[i2cm_pkg::TO_W-1:0];
                default:               tpm_reg     <= tpm_reg;
            endcase
        end
    end

    // sequencer next state
    always_comb
    begin
        phase_next = phase_reg;
        bits_next  = bits_reg;
        shift_next = shift_reg;
        delay_next = delay_reg;
        poll_next  = poll_reg;
        ackc_next  = ackc_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        drive_next = drive_reg;
        rd_next    = rd_reg;
        fail_next  = fail_reg;
        done_next  = 1'b0;

        if (in_fire)
        begin
            if (cmd.kind == i2cm_pkg::KIND_TICK)
            begin
                if (phase_reg == PH_WA_POLL)
                begin
                    if (!cmd.sda_in)
                    begin
                        scl_next   = 1'b0;
                        fail_next  = 1'b0;
                        phase_next = PH_IDLE;
                        done_next  = 1'b1;
                    end
                    else if (poll_reg >= timeout_reg)
                    begin
                        fail_next  = 1'b1;
                        drive_next = 1'b1;
                        scl_next   = 1'b0;
                        sda_next   = 1'b0;
                        phase_next = PH_STOP_A;
                        delay_next = dly4;
                    end
                    else
                    begin
                        poll_next = poll_reg + 8'd1;
                    end
                end
                else if (phase_reg != PH_IDLE)
                begin
                    // data bit sampled on the tick that raises scl
                    if (phase_reg == PH_RB_A && delay_reg <= 13'd1)
                        shift_next = {shift_reg[6:0], cmd.sda_in};

                    if (delay_reg > 13'd1)
                    begin
                        delay_next = delay_reg - 13'd1;
                    end
                    else
                    begin
                        delay_next = '0;
                        case (phase_reg)
                            PH_START:
                            begin
                                scl_next   = 1'b0;
                                phase_next = PH_IDLE;
                                done_next  = 1'b1;
                            end
                            PH_STOP_A:
                            begin
                                scl_next   = 1'b1;
                                sda_next   = 1'b1;
                                phase_next = PH_STOP_B;
                                delay_next = dly4;
                            end
                            PH_STOP_B:
                            begin
                                phase_next = PH_IDLE;
                                done_next  = 1'b1;
                            end
                            PH_WA_A:
                            begin
                                scl_next   = 1'b1;
                                phase_next = PH_WA_B;
                                delay_next = dly1;
                            end
                            PH_WA_B:
                            begin
                                poll_next  = '0;
                                phase_next = PH_WA_POLL;
                            end
                            PH_SB_A:
                            begin
                                scl_next   = 1'b1;
                                phase_next = PH_SB_B;
                                delay_next = dly2;
                            end
                            PH_SB_B:
                            begin
                                scl_next   = 1'b0;
                                phase_next = PH_SB_C;
                                delay_next = dly2;
                            end
                            PH_SB_C:
                            begin
                                bits_next = bits_inc;
                                if (bits_inc >= i2cm_pkg::BITS_PER_BYTE)
                                begin
                                    phase_next = PH_IDLE;
                                    done_next  = 1'b1;
                                end
                                else
                                begin
                                    sda_next   = shift_reg[7];
                                    shift_next = {shift_reg[6:0], 1'b0};
                                    phase_next = PH_SB_A;
                                    delay_next = dly2;
                                end
                            end
                            PH_RB_A:
                            begin
                                scl_next   = 1'b1;
                                phase_next = PH_RB_B;
                                delay_next = dly1;
                            end
                            PH_RB_B:
                            begin
                                bits_next = bits_inc;
                                scl_next  = 1'b0;
                                if (bits_inc >= i2cm_pkg::BITS_PER_BYTE)
                                begin
                                    rd_next    = shift_reg;
                                    drive_next = 1'b1;
                                    sda_next   = !ackc_reg;
                                    phase_next = PH_AK_A;
                                end
                                else
                                begin
                                    phase_next = PH_RB_A;
                                end
                                delay_next = dly2;
                            end
                            PH_AK_A:
                            begin
                                scl_next   = 1'b1;
                                phase_next = PH_AK_B;
                                delay_next = dly2;
                            end
                            PH_AK_B:
                            begin
                                scl_next   = 1'b0;
                                phase_next = PH_IDLE;
                                done_next  = 1'b1;
                            end
                            default:
                            begin
                                phase_next = PH_IDLE;
                            end
                        endcase
                    end
                end
            end
            else if (phase_reg == PH_IDLE)
            begin
                case (cmd.kind)
                    i2cm_pkg::KIND_START:
                    begin
                        drive_next = 1'b1;
                        scl_next   = 1'b1;
                        sda_next   = 1'b0;
                        phase_next = PH_START;
                        delay_next = dly4;
                    end
                    i2cm_pkg::KIND_STOP:
                    begin
                        drive_next = 1'b1;
                        scl_next   = 1'b0;
                        sda_next   = 1'b0;
                        phase_next = PH_STOP_A;
                        delay_next = dly4;
                    end
                    i2cm_pkg::KIND_WRITE:
                    begin
                        drive_next = 1'b1;
                        bits_next  = '0;
                        sda_next   = cmd.data_byte[7];
                        shift_next = {cmd.data_byte[6:0], 1'b0};
                        phase_next = PH_SB_A;
                        delay_next = dly2;
                    end
                    i2cm_pkg::KIND_WACK:
                    begin
                        drive_next = 1'b0;
                        sda_next   = 1'b1;
                        poll_next  = '0;
                        phase_next = PH_WA_A;
                        delay_next = dly1;
                    end
                    i2cm_pkg::KIND_READ:
                    begin
                        drive_next = 1'b0;
                        ackc_next  = cmd.send_ack;
                        shift_next = '0;
                        bits_next  = '0;
                        scl_next   = 1'b0;
                        phase_next = PH_RB_A;
                        delay_next = dly2;
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            bits_reg      <= '0;
            shift_reg     <= '0;
            delay_reg     <= '0;
            poll_reg      <= '0;
            ackc_reg      <= 1'b0;
            scl_reg       <= 1'b1;
            sda_reg       <= 1'b1;
            drive_reg     <= 1'b1;
            rd_reg        <= '0;
            fail_reg      <= 1'b0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            bits_reg  <= bits_next;
            shift_reg <= shift_next;
            delay_reg <= delay_next;
            poll_reg  <= poll_next;
            ackc_reg  <= ackc_next;
            scl_reg   <= scl_next;
            sda_reg   <= sda_next;
            drive_reg <= drive_next;
            rd_reg    <= rd_next;
            fail_reg  <= fail_next;
            if (in_fire)
                done_reg <= done_next;
            if (in_fire)
                out_valid_reg <= 1'b1;
            else if (res.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // state registers only change on an accepted item, so they hold the result
    assign res.valid      = out_valid_reg;
    assign res.scl_level  = scl_reg;
    assign res.sda_level  = sda_reg;
    assign res.sda_drive  = drive_reg;
    assign res.busy_res   = (phase_reg != PH_IDLE);
    assign res.done_res   = done_reg;
    assign res.read_data  = rd_reg;
    assign res.ack_failed = fail_reg;

    a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> out_valid_reg)
        else $error("accepted item gave no result");

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && done_reg |-> phase_reg == PH_IDLE)
        else $error("done reported while still busy");

    a_poll_released: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_WA_POLL |-> !drive_reg && scl_reg)
        else $error("sda driven or scl low during ack poll");

    a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !in_fire |=> $stable(phase_reg) && $stable(delay_reg))
        else $error("sequencer moved without an item");

    a_no_stall_loss: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !res.ready |-> !cmd.ready)
        else $error("item accepted over a held result");

endmodule

// ----- bench/tb_i2c_master_bit_engine_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_i2c_master_bit_engine_top
// self-checking bench for the i2c master bit engine: a behavioral copy of the
// bus sequencer predicts scl/sda levels, busy, done, read byte and ack
// failure for every accepted item; directed bus commands at the register
// extremes come first, then random command sequences under varied
// handshake idling and register settings
// ----------------------------------------------------------------------------
module tb_i2c_master_bit_engine_top;

    localparam int HOLD_CYCLES = 64;

    typedef struct packed {
        i2cm_pkg::kind_t kind;
        i2cm_pkg::byte_t data_byte;
        logic            send_ack;
        logic            sda_in;
    } bus_cmd_t;

    typedef struct packed {
        logic            scl_level;
        logic            sda_level;
        logic            sda_drive;
        logic            busy_res;
        logic            done_res;
        i2cm_pkg::byte_t read_data;
        logic            ack_failed;
    } line_state_t;

    typedef enum logic [4:0] {
        SEQ_IDLE,
        SEQ_START,
        SEQ_STOP_SETUP,
        SEQ_STOP_HOLD,
        SEQ_ACK_LOW,
        SEQ_ACK_HIGH,
        SEQ_ACK_POLL,
        SEQ_WR_SETUP,
        SEQ_WR_HIGH,
        SEQ_WR_HOLD,
        SEQ_RD_LOW,
        SEQ_RD_HIGH,
        SEQ_RA_LOW,
        SEQ_RA_HIGH
    } seq_phase_t;

    class i2c_level_scoreboard;
        i2cm_pkg::tpm_t     reg_tpm;
        i2cm_pkg::timeout_t reg_timeout;
        seq_phase_t         phase;
        i2cm_pkg::bits_t    bit_cnt;
        i2cm_pkg::byte_t    shifter;
        i2cm_pkg::delay_t   delay_left;
        i2cm_pkg::timeout_t poll_cnt;
        logic               ack_choice;
        logic               scl_q;
        logic               sda_q;
        logic               drive_q;
        logic               fail_q;
        i2cm_pkg::byte_t    rd_q;
        line_state_t        expected_levels[$];
        int unsigned        mismatches;

        function new();
            reg_tpm     = i2cm_pkg::TPM_RESET;
            reg_timeout = i2cm_pkg::TIMEOUT_RESET;
            phase       = SEQ_IDLE;
            bit_cnt     = '0;
            shifter     = '0;
            delay_left  = '0;
            poll_cnt    = '0;
            ack_choice  = 1'b0;
            scl_q       = 1'b1;
            sda_q       = 1'b1;
            drive_q     = 1'b1;
            fail_q      = 1'b0;
            rd_q        = '0;
            mismatches  = 0;
        endfunction

        function void set_registers(i2cm_pkg::tpm_t tpm, i2cm_pkg::timeout_t timeout);
            reg_tpm     = tpm;
            reg_timeout = timeout;
        endfunction

        function bit busy();
            return phase != SEQ_IDLE;
        endfunction

        function int unsigned pending();
            return expected_levels.size();
        endfunction

        function void load_delay(seq_phase_t nxt, int unsigned us);
            phase      = nxt;
            delay_left = i2cm_pkg::delay_t'(us * reg_tpm);
        endfunction

        function void begin_stop();
            drive_q = 1'b1;
            scl_q   = 1'b0;
            sda_q   = 1'b0;
            load_delay(SEQ_STOP_SETUP, 4);
        endfunction

        function void shift_out_msb();
            sda_q   = shifter[7];
            shifter = {shifter[6:0], 1'b0};
        endfunction

        // one time step of the bus sequencer, returns the done pulse
        function bit run_tick(logic sda_in);
            if (phase == SEQ_IDLE)
                return 1'b0;
            if (phase == SEQ_ACK_POLL)
            begin
                if (!sda_in)
                begin
                    scl_q  = 1'b0;
                    fail_q = 1'b0;
                    phase  = SEQ_IDLE;
                    return 1'b1;
                end
                if (poll_cnt >= reg_timeout)
                begin
                    fail_q = 1'b1;
                    begin_stop();
                end
                else
                    poll_cnt = poll_cnt + 8'd1;
                return 1'b0;
            end
            // data bit is sampled on the tick that raises scl
            if (phase == SEQ_RD_LOW && delay_left <= 13'd1)
                shifter = {shifter[6:0], sda_in};
            if (delay_left > 13'd1)
            begin
                delay_left = delay_left - 13'd1;
                return 1'b0;
            end
            delay_left = '0;
            case (phase)
                SEQ_START:
                begin
                    scl_q = 1'b0;
                    phase = SEQ_IDLE;
                    return 1'b1;
                end
                SEQ_STOP_SETUP:
                begin
                    scl_q = 1'b1;
                    sda_q = 1'b1;
                    load_delay(SEQ_STOP_HOLD, 4);
                end
                SEQ_STOP_HOLD:
                begin
                    phase = SEQ_IDLE;
                    return 1'b1;
                end
                SEQ_ACK_LOW:
                begin
                    scl_q = 1'b1;
                    load_delay(SEQ_ACK_HIGH, 1);
                end
                SEQ_ACK_HIGH:
                begin
                    poll_cnt = '0;
                    phase    = SEQ_ACK_POLL;
                end
                SEQ_WR_SETUP:
                begin
                    scl_q = 1'b1;
                    load_delay(SEQ_WR_HIGH, 2);
                end
                SEQ_WR_HIGH:
                begin
                    scl_q = 1'b0;
                    load_delay(SEQ_WR_HOLD, 2);
                end
                SEQ_WR_HOLD:
                begin
                    bit_cnt = bit_cnt + 4'd1;
                    if (bit_cnt >= i2cm_pkg::BITS_PER_BYTE)
                    begin
                        phase = SEQ_IDLE;
                        return 1'b1;
                    end
                    shift_out_msb();
                    load_delay(SEQ_WR_SETUP, 2);
                end
                SEQ_RD_LOW:
                begin
                    scl_q = 1'b1;
                    load_delay(SEQ_RD_HIGH, 1);
                end
                SEQ_RD_HIGH:
                begin
                    bit_cnt = bit_cnt + 4'd1;
                    scl_q   = 1'b0;
                    if (bit_cnt >= i2cm_pkg::BITS_PER_BYTE)
                    begin
                        rd_q    = shifter;
                        drive_q = 1'b1;
                        sda_q   = ~ack_choice;
                        load_delay(SEQ_RA_LOW, 2);
                    end
                    else
                        load_delay(SEQ_RD_LOW, 2);
                end
                SEQ_RA_LOW:
                begin
                    scl_q = 1'b1;
                    load_delay(SEQ_RA_HIGH, 2);
                end
                SEQ_RA_HIGH:
                begin
                    scl_q = 1'b0;
                    phase = SEQ_IDLE;
                    return 1'b1;
                end
                default:
                    phase = SEQ_IDLE;
            endcase
            return 1'b0;
        endfunction

        // returns 1 when the item changes the sequencer
        function bit note_command(bus_cmd_t c);
            bit          done;
            bit          effective;
            line_state_t e;
            done      = 1'b0;
            effective = 1'b0;
            if (c.kind == i2cm_pkg::KIND_TICK)
            begin
                effective = busy();
                done      = run_tick(c.sda_in);
            end
            else if (!busy())
            begin
                effective = 1'b1;
                case (c.kind)
                    i2cm_pkg::KIND_START:
                    begin
                        drive_q = 1'b1;
                        scl_q   = 1'b1;
                        sda_q   = 1'b0;
                        load_delay(SEQ_START, 4);
                    end
                    i2cm_pkg::KIND_STOP:
                        begin_stop();
                    i2cm_pkg::KIND_WRITE:
                    begin
                        drive_q = 1'b1;
                        shifter = c.data_byte;
                        bit_cnt = '0;
                        shift_out_msb();
                        load_delay(SEQ_WR_SETUP, 2);
                    end
                    i2cm_pkg::KIND_WACK:
                    begin
                        drive_q  = 1'b0;
                        sda_q    = 1'b1;
                        poll_cnt = '0;
                        load_delay(SEQ_ACK_LOW, 1);
                    end
                    i2cm_pkg::KIND_READ:
                    begin
                        drive_q    = 1'b0;
                        ack_choice = c.send_ack;
                        shifter    = '0;
                        bit_cnt    = '0;
                        scl_q      = 1'b0;
                        load_delay(SEQ_RD_LOW, 2);
                    end
                    default:
                        effective = 1'b0;
                endcase
            end
            e.scl_level  = scl_q;
            e.sda_level  = sda_q;
            e.sda_drive  = drive_q;
            e.busy_res   = busy();
            e.done_res   = done;
            e.read_data  = rd_q;
            e.ack_failed = fail_q;
            expected_levels.push_back(e);
            return effective;
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_levels(line_state_t got);
            line_state_t want;
            if (expected_levels.size() == 0)
            begin
                $error("result item with no expected levels pending");
                mismatches++;
                return;
            end
            want = expected_levels.pop_front();
            compare_field("scl_level", 8'(want.scl_level), 8'(got.scl_level));
            compare_field("sda_level", 8'(want.sda_level), 8'(got.sda_level));
            compare_field("sda_drive", 8'(want.sda_drive), 8'(got.sda_drive));
            compare_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
            compare_field("done_res", 8'(want.done_res), 8'(got.done_res));
            compare_field("read_data", want.read_data, got.read_data);
            compare_field("ack_failed", 8'(want.ack_failed), 8'(got.ack_failed));
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    i2cm_pkg::cfg_idx_t  cfg_index;
    i2cm_pkg::cfg_data_t cfg_data;

    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned hold_requests;
    int unsigned hold_served;
    int unsigned hold_left;
    int unsigned effective_items;

    i2c_level_scoreboard sequencer;

    i2cm_cmd_if cmd_ch ();
    i2cm_res_if res_ch ();

    i2c_master_bit_engine_top i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd_ch),
        .res       (res_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #(10_000_000);
        $display("Verification failed");
        $finish;
    end

    function automatic bus_cmd_t make_item(i2cm_pkg::kind_t k);
        bus_cmd_t c;
        c.kind      = k;
        c.data_byte = i2cm_pkg::byte_t'($urandom_range(255));
        c.send_ack  = 1'($urandom_range(1));
        c.sda_in    = 1'($urandom_range(1));
        return c;
    endfunction

    task automatic offer_item(input bus_cmd_t c);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid     <= 1'b1;
        cmd_ch.kind      <= c.kind;
        cmd_ch.data_byte <= c.data_byte;
        cmd_ch.send_ack  <= c.send_ack;
        cmd_ch.sda_in    <= c.sda_in;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        if (sequencer.note_command(c))
            effective_items++;
    endtask

    // command, then ticks until the bus operation completes
    task automatic run_command(input bus_cmd_t c, input int unsigned high_pct,
                               input int unsigned noise_pct);
        bus_cmd_t t;
        offer_item(c);
        while (sequencer.busy())
        begin
            if ($urandom_range(99) < noise_pct)
                offer_item(make_item(i2cm_pkg::kind_t'($urandom_range(1, 7))));
            else
            begin
                t        = make_item(i2cm_pkg::KIND_TICK);
                t.sda_in = ($urandom_range(99) < high_pct);
                offer_item(t);
            end
        end
    endtask

    task automatic drain();
        cmd_ch.valid <= 1'b0;
        while (sequencer.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_registers(input i2cm_pkg::tpm_t tpm,
                                   input i2cm_pkg::timeout_t timeout);
        cfg_we    <= 1'b1;
        cfg_index <= i2cm_pkg::CFG_TPM;
        cfg_data  <= i2cm_pkg::cfg_data_t'(tpm);
        @(posedge clk);
        cfg_index <= i2cm_pkg::CFG_TIMEOUT;
        cfg_data  <= {2'($urandom_range(3)), timeout};
        @(posedge clk);
        cfg_we    <= 1'b0;
        sequencer.set_registers(tpm, timeout);
    endtask

    task automatic directed_commands();
        bus_cmd_t c;
        c = make_item(i2cm_pkg::KIND_TICK);
        c.sda_in = 1'b0;
        offer_item(c);
        c.sda_in = 1'b1;
        offer_item(c);
        offer_item(make_item(i2cm_pkg::kind_t'(6)));
        offer_item(make_item(i2cm_pkg::kind_t'(7)));
        run_command(make_item(i2cm_pkg::KIND_START), 50, 0);
        c = make_item(i2cm_pkg::KIND_WRITE);
        c.data_byte = 8'hFF;
        run_command(c, 50, 0);
        c.data_byte = 8'h00;
        run_command(c, 50, 0);
        c.data_byte = 8'hA5;
        run_command(c, 50, 0);
        run_command(make_item(i2cm_pkg::KIND_WACK), 0, 0);
        c = make_item(i2cm_pkg::KIND_READ);
        c.send_ack = 1'b1;
        run_command(c, 50, 0);
        c.send_ack = 1'b0;
        run_command(c, 50, 0);
        // ack never comes, full timeout then stop
        run_command(make_item(i2cm_pkg::KIND_WACK), 100, 0);
        run_command(make_item(i2cm_pkg::KIND_STOP), 50, 0);
        // commands arriving mid-operation are dropped
        run_command(make_item(i2cm_pkg::KIND_START), 50, 30);
        drain();

        write_registers(i2cm_pkg::tpm_t'(0), i2cm_pkg::timeout_t'(0));
        run_command(make_item(i2cm_pkg::KIND_WACK), 100, 0);
        run_command(make_item(i2cm_pkg::KIND_READ), 50, 0);
        run_command(make_item(i2cm_pkg::KIND_WRITE), 50, 0);
        drain();

        write_registers(i2cm_pkg::tpm_t'(40), i2cm_pkg::timeout_t'(255));
        run_command(make_item(i2cm_pkg::KIND_START), 50, 0);
        run_command(make_item(i2cm_pkg::KIND_WACK), 50, 0);
        drain();

        write_registers(i2cm_pkg::tpm_t'(2), i2cm_pkg::timeout_t'(1));
        run_command(make_item(i2cm_pkg::KIND_WACK), 50, 0);
        drain();
    endtask

    task automatic random_sequences(input int unsigned budget);
        int unsigned start_count;
        start_count = effective_items;
        while (effective_items - start_count < budget)
        begin
            if ($urandom_range(9) == 0)
                offer_item(make_item(i2cm_pkg::kind_t'($urandom_range(7))));
            else
                run_command(make_item(i2cm_pkg::kind_t'($urandom_range(
                                i2cm_pkg::KIND_START, i2cm_pkg::KIND_READ))),
                            $urandom_range(100), 5);
        end
        drain();
    endtask

    // result side: checks each accepted result, stalls at random
    initial
    begin
        res_ch.ready = 1'b0;
        hold_served  = 0;
        hold_left    = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_ch.valid && res_ch.ready)
                sequencer.check_levels({res_ch.scl_level, res_ch.sda_level, res_ch.sda_drive,
                                        res_ch.busy_res, res_ch.done_res, res_ch.read_data,
                                        res_ch.ack_failed});
            if (hold_served != hold_requests)
            begin
                hold_served = hold_requests;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin
        int unsigned        tpm_plan[8];
        i2cm_pkg::timeout_t timeout;
        tpm_plan = '{1, 0, 2, 3, 1, 4, 2, 1};
        sequencer           = new();
        send_idle_pct       = 0;
        recv_stall_pct      = 0;
        hold_requests       = 0;
        effective_items     = 0;
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = i2cm_pkg::CFG_TPM;
        cfg_data            = '0;
        cmd_ch.valid        = 1'b0;
        cmd_ch.kind         = i2cm_pkg::KIND_TICK;
        cmd_ch.data_byte    = '0;
        cmd_ch.send_ack     = 1'b0;
        cmd_ch.sda_in       = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_commands();

        for (int p = 0; p < 8; p++)
        begin
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
                default: begin send_idle_pct = 19; recv_stall_pct = 19; end
            endcase
            timeout = (p == 4) ? i2cm_pkg::timeout_t'(255)
                               : i2cm_pkg::timeout_t'($urandom_range(12));
            write_registers(i2cm_pkg::tpm_t'(tpm_plan[p]), timeout);
            // long result-side hold-off so the input side backs up
            if (p == 0)
                hold_requests <= hold_requests + 1;
            random_sequences(100);
        end

        if (sequencer.mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
